>>> hw/rtl/tum_pkg.sv
// package for the trajectory unwrap / msd block
// holds the sequencer state codes and register indexes; no dependencies
package tum_pkg;
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_CUR   = 4'd2;
    localparam logic [3:0] ST_CROSS = 4'd3;
    localparam logic [3:0] ST_POS   = 4'd4;
    localparam logic [3:0] ST_SQ    = 4'd5;
    localparam logic [3:0] ST_ACC   = 4'd6;
    localparam logic [3:0] ST_ROOT  = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_BOX_X    = 3'd3;
    localparam logic [2:0] REG_BOX_Y    = 3'd4;
    localparam logic [2:0] REG_BOX_Z    = 3'd5;
endpackage

>>> hw/rtl/trajectory_unwrap_msd_top.sv
// trajectory unwrap and mean square displacement, top level
// depends on tum_pkg; one shared multiplier plus a shared shift/subtract step unit
// flow: an accepted beat runs three products on the one multiplier, then sum,
//   crossing, position, square, accumulate and output; a frame-ending axis adds
//   the root and divide steps between accumulate and output, with the divide
//   skipped when its frame time is zero
// throughput: one beat at a time, input ready again as the result enters the
//   output register; the output state waits only while an older result is still
//   held
// reset: synchronous active low, clears config, box counts, history and accum
module trajectory_unwrap_msd_top #(
    parameter int BOX_COUNT_BITS = 16,
    parameter int NUM_AXES       = 3
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] frame_time, [63:32] translation, [95:64] rot_a, [127:96] rot_b,
    // [159:128] rot_c
    input  logic [159:0] s_axis_tdata,
    // [1:0] axis
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] position, [79:32] displacement_sq, [111:80] displacement,
    // [159:112] sq_per_time
    output logic [159:0] m_axis_tdata,
    // [1:0] axis_out
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast,   // frame_done
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import tum_pkg::*;

    localparam int BC = BOX_COUNT_BITS;

    // configuration registers
    logic signed [31:0] r_origin [3];
    logic [30:0]        r_box    [3];

    // per-axis history
    logic signed [31:0] r_prev [3];
    logic signed [31:0] r_ref  [3];
    logic signed [BC-1:0] r_bidx [3];
    logic [47:0]        r_acc;
    logic               r_first;

    // item latch
    logic [1:0]         r_axis;
    logic [31:0]        r_time;
    logic signed [31:0] r_tr;
    logic signed [31:0] r_rot [3];

    logic [3:0]         r_state;
    logic [1:0]         r_k;
    logic [6:0]         r_cnt;
    logic signed [65:0] r_qsum;     // sum of floored quotients
    logic [31:0]        r_rsum;     // sum of remainders (< 3*2^30)
    logic signed [31:0] r_cur;
    logic signed [31:0] r_pos;
    logic [31:0]        r_ud;
    logic [47:0]        r_dsq;
    // shared shift/subtract unit: root and divide
    logic [63:0]        r_rem;
    logic [63:0]        r_num;
    logic [63:0]        r_root;     // partial root runs wide until the last step
    logic [63:0]        r_quo;

    // output register
    logic               r_ovalid;
    logic [159:0]       r_odata;
    logic [1:0]         r_ouser;
    logic               r_olast;

    logic wr;
    logic [2:0] ridx;
    assign wr = psel && penable && pwrite;
    assign ridx = paddr[4:2];
    assign pready = 1'b1;

    always_comb begin
        case (ridx)
            REG_ORIGIN_X: prdata = r_origin[0];
            REG_ORIGIN_Y: prdata = r_origin[1];
            REG_ORIGIN_Z: prdata = r_origin[2];
            REG_BOX_X:    prdata = {1'b0, r_box[0]};
            REG_BOX_Y:    prdata = {1'b0, r_box[1]};
            REG_BOX_Z:    prdata = {1'b0, r_box[2]};
            default:      prdata = 32'd0;
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

    // the one 33x33 multiplier, operands chosen by state
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    always_comb begin
        mul_a = 33'sd0;
        mul_b = 33'sd0;
        if (r_state == ST_MUL) begin
            mul_a = 33'(r_rot[r_k]);
            mul_b = 33'(r_origin[r_k]);
        end else if (r_state == ST_POS) begin
            mul_a = 33'(r_bidx[r_axis]);
            mul_b = signed'({2'b00, r_box[r_axis]});
        end else begin
            mul_a = signed'({1'b0, r_ud});
            mul_b = signed'({1'b0, r_ud});
        end
    end
    assign mul_p = mul_a * mul_b;

    function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
        if (v > 67'sd2147483647) return 32'sh7fffffff;
        if (v < -67'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // helpers
    logic signed [63:0] p64;
    logic signed [33:0] q_k;
    logic [29:0]        r_kk;
    assign p64  = mul_p[63:0];
    assign q_k  = 34'(p64 >>> 30);
    assign r_kk = p64[29:0];

    logic signed [33:0] dd;
    logic [33:0]        add;
    assign dd  = 34'(2) * (34'(r_prev[r_axis]) - 34'(r_cur));
    assign add = dd[33] ? 34'(-dd) : dd;

    logic signed [BC-1:0] bmax, bmin;
    assign bmax = {1'b0, {(BC-1){1'b1}}};
    assign bmin = {1'b1, {(BC-1){1'b0}}};

    // square of this axis comes straight off the multiplier in ST_ACC
    logic [49:0] acc_sum;
    logic [47:0] acc_sat;
    assign acc_sum = 50'(r_acc) + 50'(mul_p[63:16]);
    assign acc_sat = (acc_sum[49:48] != 2'b00) ? 48'hffffffffffff : acc_sum[47:0];

    // root step
    logic [63:0] bitv, trial;
    assign bitv  = 64'd1 << (7'd2 * (7'd31 - r_cnt));
    assign trial = r_root + bitv;

    logic [64:0] dtrial;
    assign dtrial = {r_rem, r_num[63]} - {33'd0, r_time};

    logic signed [33:0] dpos;
    assign dpos = 34'(r_pos) - 34'(r_ref[r_axis]);

    // result moves to the output register once the old one is gone
    logic out_load;
    assign out_load = (r_state == ST_OUT) && (!r_ovalid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_origin[i] <= '0;
                r_box[i]    <= '0;
                r_prev[i]   <= '0;
                r_ref[i]    <= '0;
                r_bidx[i]   <= '0;
            end
            r_acc    <= '0;
            r_first  <= 1'b1;
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (wr) begin
                case (ridx)
                    REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z:
                        r_origin[ridx[1:0]] <= pwdata;
                    REG_BOX_X, REG_BOX_Y, REG_BOX_Z:
                        r_box[2'(ridx - REG_BOX_X)] <= pwdata[30:0];
                    default: ;
                endcase
            end
            if (out_load) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;

            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready
                        && 32'(s_axis_tuser) < 32'(NUM_AXES)) begin
                        r_axis   <= s_axis_tuser;
                        r_time   <= s_axis_tdata[31:0];
                        r_tr     <= s_axis_tdata[63:32];
                        r_rot[0] <= s_axis_tdata[95:64];
                        r_rot[1] <= s_axis_tdata[127:96];
                        r_rot[2] <= s_axis_tdata[159:128];
                        r_k      <= '0;
                        r_qsum   <= '0;
                        r_rsum   <= '0;
                        r_state  <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_qsum <= r_qsum + 66'(q_k);
                    r_rsum <= r_rsum + 32'(r_kk);
                    if (r_k == 2'd2) r_state <= ST_CUR;
                    r_k <= r_k + 2'd1;
                end
                ST_CUR: begin
                    r_cur <= sat32(67'(r_qsum) + 67'(r_rsum[31:30]) + 67'(r_tr));
                    r_state <= ST_CROSS;
                end
                ST_CROSS: begin
                    if (r_time == 32'd0) r_ref[r_axis] <= r_cur;
                    else if (r_first)    r_ref[r_axis] <= r_origin[r_axis];
                    if (!r_first && r_box[r_axis] != 31'd0
                        && 34'(r_box[r_axis]) < add) begin
                        if (!dd[33] && r_bidx[r_axis] < bmax)
                            r_bidx[r_axis] <= r_bidx[r_axis] + BC'(1);
                        else if (dd[33] && r_bidx[r_axis] > bmin)
                            r_bidx[r_axis] <= r_bidx[r_axis] - BC'(1);
                    end
                    r_prev[r_axis] <= r_cur;
                    r_state <= ST_POS;
                end
                ST_POS: begin
                    r_pos <= sat32(67'(p64) + 67'(r_cur));
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    r_ud <= dpos[33] ? 32'(-dpos) : 32'(dpos);
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_cnt <= '0;
                    if (32'(r_axis) == 32'(NUM_AXES - 1)) begin
                        // frame end: report the sum and start over
                        r_acc   <= '0;
                        r_first <= 1'b0;
                        r_dsq   <= acc_sat;
                        r_rem   <= {acc_sat, 16'd0};
                        r_root  <= '0;
                        r_state <= ST_ROOT;
                    end else begin
                        r_acc   <= acc_sat;
                        r_state <= ST_OUT;
                    end
                end
                ST_ROOT: begin
                    // 32 restoring root steps on the shared subtract unit
                    if (r_cnt == 7'd32) begin
                        r_num <= {r_dsq, 16'd0};
                        r_rem <= '0;
                        r_quo <= '0;
                        r_cnt <= '0;
                        r_state <= ST_DIV;
                    end else begin
                        if (r_rem >= trial) begin
                            r_rem  <= r_rem - trial;
                            r_root <= (r_root >> 1) + bitv;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                ST_DIV: begin
                    if (r_time == 32'd0 || r_cnt == 7'd64) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_num <= r_num << 1;
                        if (!dtrial[64]) begin
                            r_rem <= dtrial[63:0];
                            r_quo <= {r_quo[62:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[62:0], r_num[63]};
                            r_quo <= {r_quo[62:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_ouser <= r_axis;
                        if (32'(r_axis) == 32'(NUM_AXES - 1)) begin
                            r_olast <= 1'b1;
                            r_odata <= {(r_time == 32'd0) ? 48'd0 :
                                        (r_quo[63:48] != 16'd0 ? 48'hffffffffffff
                                         : r_quo[47:0]),
                                        r_root[31:0], r_dsq, r_pos};
                        end else begin
                            r_olast <= 1'b0;
                            r_odata <= {128'd0, r_pos};
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    logic unused_ok;
    assign unused_ok = ^{mul_p[65:64]};
endmodule

>>> verif/trajectory_unwrap_msd_top_tb.sv
// testbench for trajectory_unwrap_msd_top: directed and random frames against
// an in-bench predictor of unwrapping and displacement; depends on tum_pkg and the rtl
module trajectory_unwrap_msd_top_tb;
    import tum_pkg::*;

    localparam int    BOX_BITS  = 16;
    localparam int    AXES      = 3;
    localparam longint CYC_LIMIT = 1000000;
    localparam logic [1:0] AX_X = 2'd0, AX_Y = 2'd1, AX_Z = 2'd2, AX_BAD = 2'd3;
    localparam logic [4:0] A_ORG_X = {REG_ORIGIN_X, 2'b00};
    localparam logic [4:0] A_ORG_Y = {REG_ORIGIN_Y, 2'b00};
    localparam logic [4:0] A_ORG_Z = {REG_ORIGIN_Z, 2'b00};
    localparam logic [4:0] A_BOX_X = {REG_BOX_X, 2'b00};
    localparam logic [4:0] A_BOX_Y = {REG_BOX_Y, 2'b00};
    localparam logic [4:0] A_BOX_Z = {REG_BOX_Z, 2'b00};
    localparam longint unsigned MAX48 = 64'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [1:0]         axis;
        logic [31:0]        ftime;
        logic signed [31:0] tr, ra, rb, rc;
    } t_sample;

    typedef struct packed {
        logic [1:0]  axis;
        logic [31:0] pos;
        logic        done;
        logic [47:0] dsq;
        logic [31:0] root;
        logic [47:0] per;
    } t_coord;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    // [31:0] frame_time, [63:32] translation, [95:64] rot_a, [127:96] rot_b,
    // [159:128] rot_c
    logic [159:0] s_axis_tdata = '0;
    // [1:0] axis
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    // [31:0] position, [79:32] displacement_sq, [111:80] displacement,
    // [159:112] sq_per_time
    logic [159:0] m_axis_tdata;
    // [1:0] axis_out
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    trajectory_unwrap_msd_top #(.BOX_COUNT_BITS(BOX_BITS), .NUM_AXES(AXES)) DUT (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    // predictor state
    longint          org[3], boxl[3], prev_cur[3], box_idx[3], ref_pt[3];
    longint unsigned sq_sum;
    bit              first_frm;

    t_sample pending[$];
    t_coord  expected_coords[$];
    t_sample cur_beat;
    int      send_idle, recv_idle;
    int      mismatches = 0, n_results = 0, n_frames = 0, n_cross = 0;
    longint  cycles = 0;
    int      hold_left = 0;
    logic    hold_kick = 0;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // unwrap one axis beat and queue the coordinate it should produce
    task automatic unwrap_predict(t_sample s);
        longint prod, q, qs, rs, cur, d, ad, pos, diff, rot[3];
        logic [63:0] ud, sq, dsq, per;
        t_coord c;
        int a;
        if (s.axis >= AXES) return;
        a = s.axis;
        rot[0] = s.ra; rot[1] = s.rb; rot[2] = s.rc;
        qs = 0; rs = 0;
        // floor each product separately, the exact three-way sum may not fit 64 bits
        for (int k = 0; k < 3; k++) begin
            prod = rot[k] * org[k];
            q = prod >>> 30;
            qs += q;
            rs += prod - (q <<< 30);
        end
        cur = sat32(qs + rs / 64'sd1073741824 + longint'(s.tr));
        if (s.ftime == 0) ref_pt[a] = cur;
        else if (first_frm) ref_pt[a] = org[a];
        if (!first_frm && boxl[a] != 0) begin
            d = 2 * (prev_cur[a] - cur);
            ad = d < 0 ? -d : d;
            if (boxl[a] < ad) begin
                n_cross++;
                if (d > 0 && box_idx[a] < (64'sd1 << (BOX_BITS - 1)) - 1) box_idx[a]++;
                else if (d < 0 && box_idx[a] > -(64'sd1 << (BOX_BITS - 1))) box_idx[a]--;
            end
        end
        prev_cur[a] = cur;
        pos = sat32(cur + box_idx[a] * boxl[a]);
        diff = pos - ref_pt[a];
        ud = diff < 0 ? -diff : diff;
        sq = (ud * ud) >> 16;
        sq_sum += sq;
        if (sq_sum > MAX48) sq_sum = MAX48;
        c.axis = s.axis; c.pos = pos[31:0]; c.done = (a == AXES - 1);
        c.dsq = 0; c.root = 0; c.per = 0;
        if (c.done) begin
            dsq = sq_sum;
            c.dsq = dsq[47:0];
            c.root = int_sqrt(dsq << 16);
            if (s.ftime != 0) begin
                per = (dsq << 16) / s.ftime;
                if (per > MAX48) per = MAX48;
                c.per = per[47:0];
            end
            sq_sum = 0;
            first_frm = 0;
        end
        expected_coords.push_back(c);
    endtask

    // driver: one beat offered at a time, prediction at acceptance
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) unwrap_predict(cur_beat);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending.size() != 0 && $urandom_range(99) >= send_idle) begin
                    cur_beat = pending.pop_front();
                    s_axis_tdata  <= {cur_beat.rc, cur_beat.rb, cur_beat.ra,
                                      cur_beat.tr, cur_beat.ftime};
                    s_axis_tuser  <= cur_beat.axis;
                    s_axis_tvalid <= 1;
                end else begin
                    s_axis_tvalid <= 0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_kick) hold_left <= 400;
        else if (hold_left > 0) hold_left <= hold_left - 1;
    end

    // monitor: compare every taken result with the oldest expectation
    always @(posedge i_clk) begin
        t_coord e;
        t_coord g;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                g.axis = m_axis_tuser; g.pos = m_axis_tdata[31:0]; g.done = m_axis_tlast;
                g.dsq = m_axis_tdata[79:32]; g.root = m_axis_tdata[111:80];
                g.per = m_axis_tdata[159:112];
                n_results++;
                if (expected_coords.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: axis %0d pos %h", g.axis, g.pos);
                end else begin
                    e = expected_coords.pop_front();
                    if (g.done) n_frames++;
                    if (e != g) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch exp ax%0d pos %h last %b dsq %h rt %h per %h",
                                     e.axis, e.pos, e.done, e.dsq, e.root, e.per);
                            $display("         act ax%0d pos %h last %b dsq %h rt %h per %h",
                                     g.axis, g.pos, g.done, g.dsq, g.root, g.per);
                        end
                    end
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic apb_write(logic [4:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (addr < A_BOX_X) org[addr >> 2] = longint'($signed(data));
        else boxl[(addr >> 2) - 3] = data[30:0];
    endtask

    task automatic set_cfg(logic [31:0] ox, oy, oz, bx, by, bz);
        apb_write(A_ORG_X, ox); apb_write(A_ORG_Y, oy); apb_write(A_ORG_Z, oz);
        apb_write(A_BOX_X, bx); apb_write(A_BOX_Y, by); apb_write(A_BOX_Z, bz);
    endtask

    // sender pause: nothing left to send and every result back, then latency margin
    task automatic drain();
        while (pending.size() != 0 || s_axis_tvalid || expected_coords.size() != 0)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    function automatic t_sample mk(logic [1:0] ax, logic [31:0] t, logic [31:0] tr,
                                   logic [31:0] a, logic [31:0] b, logic [31:0] c);
        t_sample s;
        s.axis = ax; s.ftime = t; s.tr = tr; s.ra = a; s.rb = b; s.rc = c;
        return s;
    endfunction

    function automatic logic [31:0] rnd32();
        return $urandom;
    endfunction

    // mostly well-formed frames with a random walk and occasional big jumps
    task automatic random_frames(int n_items);
        logic [31:0] tnow, rot_a, rot_b, rot_c;
        longint walk[3];
        int sent, pick;
        tnow = 0; sent = 0;
        for (int k = 0; k < 3; k++) walk[k] = $signed(rnd32()) >>> 8;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                // noise: ignored axis, lone axis, or fully random fields
                pending.push_back(mk(2'($urandom_range(3)), rnd32(), rnd32(), rnd32(),
                                     rnd32(), rnd32()));
                sent++;
            end else begin
                if ($urandom_range(9) == 0) tnow = 0;
                else if ($urandom_range(19) == 0) tnow = rnd32();
                else tnow = tnow + $urandom_range(1, 1 << 20);
                for (int k = 0; k < AXES; k++) begin
                    // a broken frame now and then: the x or y axis, or both, left out
                    if (pick < 14 && k == $urandom_range(1)) continue;
                    if ($urandom_range(3) == 0)
                        walk[k] += $signed(rnd32()) >>> $urandom_range(1, 12);
                    else
                        walk[k] += $signed(rnd32()) >>> 18;
                    walk[k] = sat32(walk[k]);
                    rot_a = $signed(rnd32()) >>> $urandom_range(1, 3);
                    rot_b = $signed(rnd32()) >>> $urandom_range(1, 3);
                    rot_c = $signed(rnd32()) >>> $urandom_range(1, 3);
                    pending.push_back(mk(2'(k), tnow, walk[k][31:0], rot_a, rot_b, rot_c));
                    sent++;
                end
            end
        end
    endtask

    localparam logic [31:0] MAXP = 32'h7FFF_FFFF, MINN = 32'h8000_0000;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000, ONE_Q16 = 32'h0001_0000;

    initial begin
        org = '{0, 0, 0}; boxl = '{0, 0, 0};
        prev_cur = '{0, 0, 0}; box_idx = '{0, 0, 0}; ref_pt = '{0, 0, 0};
        sq_sum = 0; first_frm = 1;
        send_idle = 13; recv_idle = 82;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        repeat (2) @(posedge i_clk);

        // directed: extremes, ignored axis, reference restart, crossings, odd axis order
        set_cfg(ONE_Q16, 32'hFFFF_0000, MAXP, 32'h0008_0000, 32'h7FFF_FFFF, 32'd0);
        pending.push_back(mk(AX_X, 32'd0, 32'd0, ONE_Q30, 0, 0));
        pending.push_back(mk(AX_Y, 32'd0, MAXP, MAXP, MAXP, MAXP));
        pending.push_back(mk(AX_Z, 32'd0, MINN, MINN, MINN, MINN));
        pending.push_back(mk(AX_BAD, rnd32(), rnd32(), rnd32(), rnd32(), rnd32()));
        pending.push_back(mk(AX_X, 32'd100, 32'h0006_0000, ONE_Q30, 0, 0));
        pending.push_back(mk(AX_Y, 32'd100, MINN, MINN, MAXP, 0));
        pending.push_back(mk(AX_Z, 32'hFFFF_FFFF, MAXP, 0, 0, MAXP));
        pending.push_back(mk(AX_X, 32'd200, 32'hFFFA_0000, ONE_Q30, 0, 0));
        pending.push_back(mk(AX_X, 32'd201, 32'h0005_0000, ONE_Q30, 0, 0));
        pending.push_back(mk(AX_Z, 32'd1, MAXP, MAXP, MAXP, MAXP));
        pending.push_back(mk(AX_Y, 32'd300, MAXP, 0, 0, 0));
        pending.push_back(mk(AX_Y, 32'd301, MINN, 0, 0, 0));
        pending.push_back(mk(AX_Z, 32'd302, MINN, MINN, MINN, MINN));
        pending.push_back(mk(AX_X, 32'd0, 32'd0, 0, 0, 0));
        pending.push_back(mk(AX_Y, 32'd0, 32'd0, 0, 0, 0));
        pending.push_back(mk(AX_Z, 32'd0, 32'd0, 0, 0, 0));
        pending.push_back(mk(AX_BAD, 32'd0, 32'd0, 0, 0, 0));
        drain();

        random_frames(130);
        // hold the output off long enough for the block to stall its input
        @(posedge i_clk) hold_kick <= 1;
        @(posedge i_clk) hold_kick <= 0;
        drain();

        send_idle = 82; recv_idle = 13;
        set_cfg(MINN, MAXP, 32'h0000_0001, 32'h0001_0000, 32'h0000_0001, 32'h7FFF_FFFF);
        random_frames(130);
        drain();

        send_idle = 0; recv_idle = 0;
        set_cfg(rnd32(), rnd32(), rnd32(), 32'h0040_0000, 32'd0, 32'h0010_0000);
        random_frames(140);
        drain();

        $display("%0d coordinates checked, %0d frames closed, %0d box crossings predicted",
                 n_results, n_frames, n_cross);
        $display("three register settings, idle mixes on both sides, one long output stall");
        if (mismatches == 0 && expected_coords.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, expected_coords.size());
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
